// File: design/bmd_pkg.sv
// Shared types and constants for the RGGB Malvar-He-Cutler demosaic.
// No dependencies; used by bayer_malvar_demosaic.
package bmd_pkg;

	// Fixed field widths of the stream items and registers
	localparam int PIX_W      = 16;
	localparam int ROW_W      = 16;
	localparam int COL_W      = 12;
	localparam int FW_W       = 13;
	localparam int FH_W       = 16;
	localparam int PB_W       = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_DATA_W = 80;

	// Register reset values
	localparam logic [FW_W-1:0] FW_RESET = 13'd1920;
	localparam logic [FH_W-1:0] FH_RESET = 16'd1080;
	localparam logic [PB_W-1:0] PB_RESET = 5'd10;

	// Configuration register indices
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_PIXEL_BITS   = 2'd2
	} cfg_reg_t;

	// Per-item position data carried alongside the window pipeline
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
		logic             row_odd;
		logic             col_odd;
	} meta_t;

endpackage

// File: design/bayer_malvar_demosaic.sv
// RGGB Bayer to RGB demosaic, Malvar-He-Cutler 5x5 kernels.
// Depends on bmd_pkg and bmd_ram.
//
// Raw samples enter on the s_ stream in raster order, one item per clock
// sustained while s_tready is high, and fully pipelined. Each item passes
// stages 1 to 4 and then the output register. Four line
// stores (one bmd_ram per line, MAX_WIDTH deep) are each read once and one
// of them written once per item at the current column; that single access
// per store per cycle is what sets the one-item-per-clock rate. The 5x5
// window is a register array fed by the store read data. Pixels within two
// rows or columns of any frame edge give no result; every interior pixel
// gives one RGB item, with m_tlast on the last interior pixel of the frame.
// s_tuser marks the top-left pixel and restarts the position counters;
// without it frames follow each other by count alone. A result waiting on
// m_tready does not stop input: a skid register absorbs one more result,
// and s_tready drops only while that register is full. The line stores
// need no clearing after reset. Configuration writes are always accepted
// and must be made only while no item is in flight. frame_width above
// MAX_WIDTH acts as MAX_WIDTH, pixel_bits above SAMPLE_WIDTH acts as
// SAMPLE_WIDTH, and a zero width or height acts as one.
module bayer_malvar_demosaic #(
	parameter int MAX_WIDTH    = 4096,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [bmd_pkg::PIX_W-1:0]        s_tdata,   // [15:0] raw_pixel
	input  logic                             s_tuser,   // [0] first_of_frame
	// output stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [15:0] red, [31:16] green, [47:32] blue, [63:48] out_row,
	// [75:64] out_col, [79:76] zero
	output logic [bmd_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                             m_tlast,   // last
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bmd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bmd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int WW   = (AW + 1 > bmd_pkg::FW_W) ? AW + 1 : bmd_pkg::FW_W;
	localparam int CCW  = (AW > bmd_pkg::COL_W) ? AW : bmd_pkg::COL_W;
	localparam int PW   = SAMPLE_WIDTH + 2;   // sum of up to four samples
	localparam int SUMW = SAMPLE_WIDTH + 6;   // signed kernel result
	localparam int LW   = SAMPLE_WIDTH + 1;
	localparam int RW1  = bmd_pkg::ROW_W + 1;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [bmd_pkg::FW_W-1:0] fw_q;
	logic [bmd_pkg::FH_W-1:0] fh_q;
	logic [bmd_pkg::PB_W-1:0] pb_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= bmd_pkg::FW_RESET;
			fh_q <= bmd_pkg::FH_RESET;
			pb_q <= bmd_pkg::PB_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (bmd_pkg::cfg_reg_t'(cfg_index))
				bmd_pkg::REG_FRAME_WIDTH:  fw_q <= cfg_data[bmd_pkg::FW_W-1:0];
				bmd_pkg::REG_FRAME_HEIGHT: fh_q <= cfg_data[bmd_pkg::FH_W-1:0];
				bmd_pkg::REG_PIXEL_BITS:   pb_q <= cfg_data[bmd_pkg::PB_W-1:0];
				default: ;  // unused index, ignored
			endcase
		end
	end

	// Effective frame size and saturation limit
	logic [WW-1:0]                w_cap, w_eff;
	logic [bmd_pkg::FH_W-1:0]     h_eff;
	logic [bmd_pkg::PB_W-1:0]     bits_eff;
	logic [LW-1:0]                lim_wide;
	logic [SAMPLE_WIDTH-1:0]      limit;

	always_comb begin
		w_cap    = (WW'(fw_q) > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(fw_q);
		w_eff    = (w_cap == '0) ? WW'(1) : w_cap;
		h_eff    = (fh_q == '0) ? bmd_pkg::FH_W'(1) : fh_q;
		bits_eff = (pb_q > bmd_pkg::PB_W'(SAMPLE_WIDTH)) ?
			bmd_pkg::PB_W'(SAMPLE_WIDTH) : pb_q;
		lim_wide = (LW'(1) << bits_eff) - LW'(1);
		limit    = lim_wide[SAMPLE_WIDTH-1:0];
	end

	// ------------------------------------------------------------------
	// Pipeline control: everything advances unless the skid is full
	// ------------------------------------------------------------------
	logic adv;
	logic accept;
	logic skid_valid_q;

	assign adv      = !skid_valid_q;
	assign s_tready = adv;
	assign accept   = s_tvalid && s_tready;

	// ------------------------------------------------------------------
	// Input stage: position counters, line store access
	// ------------------------------------------------------------------
	logic [AW-1:0]              col_q;
	logic [bmd_pkg::ROW_W-1:0]  row_q;
	logic [AW-1:0]              col_cur;
	logic [bmd_pkg::ROW_W-1:0]  row_cur;
	logic [WW-1:0]              col_inc;
	logic [RW1-1:0]             row_inc;
	logic                       col_wrap, row_wrap;
	logic                       emit;
	logic [CCW-1:0]             cc_full;
	logic [SAMPLE_WIDTH-1:0]    pix;
	bmd_pkg::meta_t             meta_in;

	always_comb begin
		pix      = s_tdata[SAMPLE_WIDTH-1:0];
		col_cur  = (s_tuser || (WW'(col_q) >= w_eff)) ? '0 : col_q;
		row_cur  = (s_tuser || (row_q >= h_eff)) ? '0 : row_q;
		col_inc  = WW'(col_cur) + WW'(1);
		row_inc  = RW1'(row_cur) + RW1'(1);
		col_wrap = col_inc >= w_eff;
		row_wrap = row_inc >= RW1'(h_eff);
		// window centre sits two rows and two columns behind
		emit     = (row_cur >= bmd_pkg::ROW_W'(4)) && (WW'(col_cur) >= WW'(4));
		cc_full  = CCW'(col_cur) - CCW'(2);
		meta_in.row     = row_cur - bmd_pkg::ROW_W'(2);
		meta_in.col     = cc_full[bmd_pkg::COL_W-1:0];
		meta_in.last    = (row_inc == RW1'(h_eff)) && (col_inc == w_eff);
		meta_in.row_odd = row_cur[0];
		meta_in.col_odd = col_cur[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_inc[bmd_pkg::ROW_W-1:0];
			end else begin
				col_q <= col_inc[AW-1:0];
				row_q <= row_cur;
			end
		end
	end

	// Four line stores, one per row modulo four. Store row_cur%4 holds the
	// row four above until this write replaces it; read-before-write.
	logic [SAMPLE_WIDTH-1:0] line_rd [4];

	for (genvar i = 0; i < 4; i++) begin : g_line
		bmd_ram #(
			.WIDTH(SAMPLE_WIDTH),
			.DEPTH(MAX_WIDTH)
		) u_line (
			.clk  (clk),
			.we   (accept && (row_cur[1:0] == 2'(i))),
			.waddr(col_cur),
			.wdata(pix),
			.re   (accept),
			.raddr(col_cur),
			.rdata(line_rd[i])
		);
	end

	// ------------------------------------------------------------------
	// Stage 1: store read data arrives, window shifts
	// ------------------------------------------------------------------
	logic                    valid_s1;
	logic                    emit_s1;
	logic [1:0]              lane_s1;
	logic [SAMPLE_WIDTH-1:0] pix_s1;
	bmd_pkg::meta_t          meta_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1 <= emit;
			lane_s1 <= row_cur[1:0];
			pix_s1  <= pix;
			meta_s1 <= meta_in;
		end
	end

	logic [SAMPLE_WIDTH-1:0] win_q [5][5];

	// lane (row+y)%4 holds row-4+y; bottom row is the new sample
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			for (int y = 0; y < 5; y++) begin
				for (int x = 0; x < 4; x++) begin
					win_q[y][x] <= win_q[y][x+1];
				end
			end
			for (int y = 0; y < 4; y++) begin
				win_q[y][4] <= line_rd[lane_s1 + 2'(y)];
			end
			win_q[4][4] <= pix_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: window valid, form the neighbour pair and quad sums
	// ------------------------------------------------------------------
	logic           valid_s2;
	bmd_pkg::meta_t meta_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			meta_s2 <= meta_s1;
		end
	end

	logic                    valid_s3;
	bmd_pkg::meta_t          meta_s3;
	logic [SAMPLE_WIDTH-1:0] cen_s3;
	logic [PW-1:0]           h1_s3, v1_s3, p2h_s3, p2v_s3, diag_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			meta_s3 <= meta_s2;
			cen_s3  <= win_q[2][2];
			h1_s3   <= PW'(win_q[2][1]) + PW'(win_q[2][3]);
			v1_s3   <= PW'(win_q[1][2]) + PW'(win_q[3][2]);
			p2h_s3  <= PW'(win_q[2][0]) + PW'(win_q[2][4]);
			p2v_s3  <= PW'(win_q[0][2]) + PW'(win_q[4][2]);
			diag_s3 <= PW'(win_q[1][1]) + PW'(win_q[1][3])
				+ PW'(win_q[3][1]) + PW'(win_q[3][3]);
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: kernels and per-site selection
	// ------------------------------------------------------------------
	logic signed [SUMW-1:0] cen_x, h1_x, v1_x, p2h_x, p2v_x, diag_x;
	logic signed [SUMW-1:0] cross1, cross2;
	logic signed [SUMW-1:0] hor, ver, rbx, gx;
	logic signed [SUMW-1:0] rv, gv, bv;
	logic                   ri, gi, bi;

	always_comb begin
		cen_x  = signed'(SUMW'(cen_s3));
		h1_x   = signed'(SUMW'(h1_s3));
		v1_x   = signed'(SUMW'(v1_s3));
		p2h_x  = signed'(SUMW'(p2h_s3));
		p2v_x  = signed'(SUMW'(p2v_s3));
		diag_x = signed'(SUMW'(diag_s3));
		cross1 = h1_x + v1_x;
		cross2 = p2h_x + p2v_x;
		// colour left/right of a green site
		hor = (cen_x <<< 2) + cen_x - p2h_x - diag_x + (p2v_x >>> 1) + (h1_x <<< 2);
		// colour above/below a green site
		ver = (cen_x <<< 2) + cen_x - p2v_x - diag_x + (p2h_x >>> 1) + (v1_x <<< 2);
		// opposite colour at an R or B site
		rbx = (cen_x <<< 2) + (cen_x <<< 1) - (((cross2 <<< 1) + cross2) >>> 1)
			+ (diag_x <<< 1);
		// green at an R or B site
		gx  = (cen_x <<< 2) - cross2 + (cross1 <<< 1);

		unique case ({meta_s3.row_odd, meta_s3.col_odd})
			2'b00: begin  // R
				rv = cen_x; gv = gx;    bv = rbx;
				ri = 1'b0;  gi = 1'b1;  bi = 1'b1;
			end
			2'b01: begin  // Gr
				rv = hor;   gv = cen_x; bv = ver;
				ri = 1'b1;  gi = 1'b0;  bi = 1'b1;
			end
			2'b10: begin  // Gb
				rv = ver;   gv = cen_x; bv = hor;
				ri = 1'b1;  gi = 1'b0;  bi = 1'b1;
			end
			default: begin  // B
				rv = rbx;   gv = gx;    bv = cen_x;
				ri = 1'b1;  gi = 1'b1;  bi = 1'b0;
			end
		endcase
	end

	logic                   valid_s4;
	bmd_pkg::meta_t         meta_s4;
	logic signed [SUMW-1:0] rv_s4, gv_s4, bv_s4;
	logic                   ri_s4, gi_s4, bi_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s3) begin
			meta_s4 <= meta_s3;
			rv_s4   <= rv;
			gv_s4   <= gv;
			bv_s4   <= bv;
			ri_s4   <= ri;
			gi_s4   <= gi;
			bi_s4   <= bi;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: floor, scale interpolated values, saturate
	// ------------------------------------------------------------------
	function automatic logic [SAMPLE_WIDTH-1:0] finish_val(
		input logic signed [SUMW-1:0] v,
		input logic                   interp,
		input logic [SAMPLE_WIDTH-1:0] lim
	);
		logic signed [SUMW-1:0] f;
		logic signed [SUMW-1:0] lim_x;
		begin
			lim_x = signed'(SUMW'(lim));
			f = v[SUMW-1] ? '0 : v;
			if (interp) begin
				f = f >>> 3;
			end
			if (f > lim_x) begin
				f = lim_x;
			end
			return f[SAMPLE_WIDTH-1:0];
		end
	endfunction

	logic [SAMPLE_WIDTH-1:0]         red_v, green_v, blue_v;
	logic [bmd_pkg::OUT_DATA_W-1:0]  pipe_data;
	logic                            take;

	always_comb begin
		red_v     = finish_val(rv_s4, ri_s4, limit);
		green_v   = finish_val(gv_s4, gi_s4, limit);
		blue_v    = finish_val(bv_s4, bi_s4, limit);
		pipe_data = {4'b0000, meta_s4.col, meta_s4.row,
			bmd_pkg::PIX_W'(blue_v), bmd_pkg::PIX_W'(green_v),
			bmd_pkg::PIX_W'(red_v)};
		take      = adv && valid_s4;
	end

	// ------------------------------------------------------------------
	// Output register and skid register
	// ------------------------------------------------------------------
	logic                           out_valid_q;
	logic [bmd_pkg::OUT_DATA_W-1:0] out_data_q;
	logic                           out_last_q;
	logic [bmd_pkg::OUT_DATA_W-1:0] skid_data_q;
	logic                           skid_last_q;
	logic                           out_free;

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || take;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
				out_last_q <= skid_last_q;
			end else begin
				out_data_q <= pipe_data;
				out_last_q <= meta_s4.last;
			end
		end else if (take) begin
			skid_data_q <= pipe_data;
			skid_last_q <= meta_s4.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> m_tvalid)
		else $error("skid holds an item while the output register is empty");

	a_skid_fill_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(m_tvalid && !m_tready))
		else $error("skid filled without a stalled output");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted item missing from first stage");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && !adv) |=> valid_s4)
		else $error("stalled result dropped from last stage");

endmodule

// File: design/bmd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read-before-write on a shared address. No dependencies.
module bmd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: dv/tb_bayer_malvar_demosaic.sv
`timescale 1ns / 1ps
// Self-checking testbench for bayer_malvar_demosaic: RGGB raw stream in, RGB items out.
// Depends on bmd_pkg and the demosaic RTL; keeps its own line-store and window predictor.
module tb_bayer_malvar_demosaic;
	import bmd_pkg::*;

	localparam int LINE_DEPTH   = 4096;  // MAX_WIDTH of the instance
	localparam int SAMPLE_MAX_W = 16;    // SAMPLE_WIDTH of the instance
	localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
	localparam int DRAIN_CYCLES = 16;    // covers the pipeline stages plus skid
	localparam int RANDOM_ITEMS = 100;
	// index 3 has no register behind it; writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// one RGB item as it leaves the block
	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} rgb_pixel_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [PIX_W-1:0]      s_tdata   = '0;
	logic                  s_tuser   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// predictor state: four line stores, the 5x5 window, counters, registers
	logic [PIX_W-1:0] line_mem [4][LINE_DEPTH];
	logic [PIX_W-1:0] win [5][5];
	int unsigned      col_pos;
	int unsigned      row_pos;
	logic [FW_W-1:0]  width_reg;
	logic [FH_W-1:0]  height_reg;
	logic [PB_W-1:0]  bits_reg;

	rgb_pixel_t expected_rgb[$];
	int         fail_count   = 0;
	int         items_sent   = 0;

	// idling control shared by the sides
	bit sender_steady   = 1'b0;
	bit receiver_steady = 1'b0;
	bit hold_request    = 1'b0;
	int hold_left       = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	bayer_malvar_demosaic #(
		.MAX_WIDTH    (LINE_DEPTH),
		.SAMPLE_WIDTH (SAMPLE_MAX_W)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	// window tap relative to the centre, zero-extended
	function automatic longint tap(int dy, int dx);
		return longint'({48'd0, win[2 + dy][2 + dx]});
	endfunction

	// floor at zero, drop 3 fraction bits on interpolated channels, saturate
	function automatic logic [PIX_W-1:0] finish_channel(longint v, bit interp, longint lim);
		if (v < 0)
			v = 0;
		if (interp)
			v = v >>> 3;
		if (v > lim)
			v = lim;
		return v[PIX_W-1:0];
	endfunction

	// advance the predictor by one raw sample; queue an RGB item for interior centres
	function automatic void predict_demosaic(logic [PIX_W-1:0] pix, logic sof);
		int unsigned w, h, bits, r, c, cr, cc, y, x;
		longint      lim, cen, cross1, cross2, diag, hor, ver, rv, gv, bv;
		bit          ri, gi, bi;
		rgb_pixel_t  res;

		// effective sizes: wide widths clamp, zero sizes act as one
		w = width_reg;
		if (w > LINE_DEPTH)
			w = LINE_DEPTH;
		if (w == 0)
			w = 1;
		h = height_reg;
		if (h == 0)
			h = 1;
		bits = bits_reg;
		if (bits > SAMPLE_MAX_W)
			bits = SAMPLE_MAX_W;
		lim = (longint'(1) << bits) - 1;

		if (sof) begin
			col_pos = 0;
			row_pos = 0;
		end
		if (col_pos >= w)
			col_pos = 0;
		if (row_pos >= h)
			row_pos = 0;
		r = row_pos;
		c = col_pos;

		// slide window left, new column from the stores and the incoming sample
		for (y = 0; y < 5; y++)
			for (x = 0; x < 4; x++)
				win[y][x] = win[y][x + 1];
		for (y = 0; y < 4; y++)
			win[y][4] = line_mem[(r + y) % 4][c];
		win[4][4] = pix;
		line_mem[r % 4][c] = pix;

		// centre is two rows and two columns behind the incoming sample
		if (r >= 4 && c >= 4) begin
			cr = r - 2;
			cc = c - 2;
			cen    = tap(0, 0);
			cross1 = tap(-1, 0) + tap(1, 0) + tap(0, -1) + tap(0, 1);
			cross2 = tap(-2, 0) + tap(2, 0) + tap(0, -2) + tap(0, 2);
			diag   = tap(-1, -1) + tap(-1, 1) + tap(1, -1) + tap(1, 1);
			// colour lying left/right of a green site
			hor = 5 * cen - tap(0, -2) - tap(0, 2) - diag
				+ ((tap(-2, 0) + tap(2, 0)) >>> 1) + 4 * (tap(0, -1) + tap(0, 1));
			// colour lying above/below a green site
			ver = 5 * cen - tap(-2, 0) - tap(2, 0) - diag
				+ ((tap(0, -2) + tap(0, 2)) >>> 1) + 4 * (tap(-1, 0) + tap(1, 0));
			ri = 1'b1;
			gi = 1'b1;
			bi = 1'b1;
			if (!cr[0] && !cc[0]) begin
				// red site
				rv = cen;
				ri = 1'b0;
				gv = 4 * cen - cross2 + 2 * cross1;
				bv = 6 * cen - ((3 * cross2) >>> 1) + 2 * diag;
			end else if (!cr[0]) begin
				// green on a red row
				rv = hor;
				gv = cen;
				gi = 1'b0;
				bv = ver;
			end else if (!cc[0]) begin
				// green on a blue row: red pair is summed, not subtracted
				rv = ver;
				gv = cen;
				gi = 1'b0;
				bv = hor;
			end else begin
				// blue site
				rv = 6 * cen - ((3 * cross2) >>> 1) + 2 * diag;
				gv = 4 * cen - cross2 + 2 * cross1;
				bv = cen;
				bi = 1'b0;
			end
			res.red   = finish_channel(rv, ri, lim);
			res.green = finish_channel(gv, gi, lim);
			res.blue  = finish_channel(bv, bi, lim);
			res.row   = cr[ROW_W-1:0];
			res.col   = cc[COL_W-1:0];
			res.last  = (r + 1 == h) && (c + 1 == w);
			expected_rgb.push_back(res);
		end

		// raster counters, frames wrap on count alone
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1 >= h) ? 0 : r + 1;
		end else
			col_pos = c + 1;
	endfunction

	// ---------------------------------------------------------------
	// Drivers (all called and returning at a falling edge)
	// ---------------------------------------------------------------

	task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic sof);
		// random sender gaps, ~25 % of cycles
		while (!sender_steady && $urandom_range(99) < 25) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = pix;
		s_tuser  = sof;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_demosaic(pix, sof);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_FRAME_WIDTH:  width_reg  = data[FW_W-1:0];
			REG_FRAME_HEIGHT: height_reg = data[FH_W-1:0];
			REG_PIXEL_BITS:   bits_reg   = data[PB_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// stop offering, let every expected item out, then let the pipe empty
	task automatic wait_quiet();
		s_tvalid = 1'b0;
		while (expected_rgb.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	// bits above each register's width are random so that masking is exercised
	task automatic configure_frame(input int w, input int h, input int bits);
		logic [CFG_DATA_W-1:0] d;
		wait_quiet();
		d = CFG_DATA_W'($urandom);
		d[FW_W-1:0] = FW_W'(w);
		write_reg(REG_FRAME_WIDTH, d);
		write_reg(REG_FRAME_HEIGHT, FH_W'(h));
		d = CFG_DATA_W'($urandom);
		d[PB_W-1:0] = PB_W'(bits);
		write_reg(REG_PIXEL_BITS, d);
	endtask

	function automatic logic [PIX_W-1:0] random_sample(int extreme_pct);
		if ($urandom_range(99) < extreme_pct)
			return $urandom_range(1) ? '1 : '0;
		return PIX_W'($urandom);
	endfunction

	task automatic send_raster(input int count, input bit mark_first, input int extreme_pct);
		int i;
		for (i = 0; i < count; i++)
			send_pixel(random_sample(extreme_pct), mark_first && i == 0);
	endtask

	// ---------------------------------------------------------------
	// Receiver: random ready, plus a counted hold-off on request
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left    = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else
			m_tready <= receiver_steady || ($urandom_range(99) >= 25);
	end

	// ---------------------------------------------------------------
	// Checker: every accepted item against the oldest expectation
	// ---------------------------------------------------------------
	task automatic compare_field(input string name, input logic [PIX_W-1:0] want,
			input logic [PIX_W-1:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : check_rgb
		rgb_pixel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_rgb.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected item, expected none, got %h last %b",
					$time, m_tdata, m_tlast);
			end else begin
				want = expected_rgb.pop_front();
				compare_field("red",     want.red,   m_tdata[15:0]);
				compare_field("green",   want.green, m_tdata[31:16]);
				compare_field("blue",    want.blue,  m_tdata[47:32]);
				compare_field("out_row", want.row,   m_tdata[63:48]);
				compare_field("out_col", PIX_W'(want.col),  PIX_W'(m_tdata[75:64]));
				compare_field("last",    PIX_W'(want.last), PIX_W'(m_tlast));
			end
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// smallest frame, every sample 0 or full scale: flooring and saturation
	// at all four Bayer sites, with pixel_bits still at its reset value
	task automatic test_extreme_pixels();
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'($urandom);
		d[FW_W-1:0] = FW_W'(6);
		write_reg(REG_FRAME_WIDTH, d);
		write_reg(REG_FRAME_HEIGHT, FH_W'(6));
		send_raster(36, 1'b1, 100);
	endtask

	// odd sizes, frames back to back with only the first one marked
	task automatic test_frame_wrap();
		configure_frame(7, 9, 16);
		send_raster(63, 1'b1, 10);
		send_raster(63, 1'b0, 10);
		send_raster(63, 1'b0, 10);
	endtask

	// frame start mark in the middle of a frame restarts the counters
	task automatic test_restart();
		configure_frame(10, 8, 12);
		send_raster(37, 1'b1, 10);
		send_raster(80, 1'b1, 10);
	endtask

	// sizes with no or one interior row or column, zero sizes, the unmapped index
	task automatic test_degenerate_sizes();
		configure_frame(0, 0, 10);
		write_reg(REG_SPARE, CFG_DATA_W'($urandom));
		send_raster(20, 1'b1, 10);
		configure_frame(1, 9, 10);
		send_raster(18, 1'b1, 10);
		configure_frame(5, 12, 10);
		send_raster(60, 1'b1, 10);
		configure_frame(12, 5, 10);
		send_raster(60, 1'b1, 10);
	endtask

	// saturation limits from zero up to beyond the sample width
	task automatic test_pixel_bits();
		int b [5] = '{0, 8, 16, 17, 31};
		int k;
		for (k = 0; k < 5; k++) begin
			configure_frame(6, 6, b[k]);
			send_raster(36, 1'b1, 40);
		end
	endtask

	// a whole frame with no idling on either side, then the tallest
	// height, run only far enough to give a few items
	task automatic test_steady_stream();
		configure_frame(24, 8, 12);
		sender_steady   = 1'b1;
		receiver_steady = 1'b1;
		send_raster(24 * 8, 1'b1, 5);
		sender_steady   = 1'b0;
		receiver_steady = 1'b0;
		configure_frame(6, 65535, 9);
		send_raster(6 * 6, 1'b1, 5);
	endtask

	// receiver holds off while the sender keeps offering: skid fills, input stalls
	task automatic test_hold_off();
		configure_frame(16, 6, 10);
		sender_steady = 1'b1;
		@(posedge clk);
		hold_request = 1'b1;
		@(negedge clk);
		send_raster(96, 1'b1, 10);
		sender_steady = 1'b0;
	endtask

	// random small frames: mostly whole frames, some unmarked successors,
	// some cut short and restarted
	task automatic test_random_frames();
		int w, h, bits, pct, frames, f, start;
		bit mark, need_mark;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			w    = ($urandom_range(7) == 0) ? $urandom_range(17, 40) : $urandom_range(6, 16);
			h    = $urandom_range(6, 9);
			bits = ($urandom_range(4) == 0) ? $urandom_range(0, 31) : $urandom_range(8, 16);
			pct  = $urandom_range(0, 30);
			configure_frame(w, h, bits);
			sender_steady   = ($urandom_range(5) == 0);
			receiver_steady = ($urandom_range(5) == 0);
			frames    = $urandom_range(1, 2);
			need_mark = 1'b1;
			for (f = 0; f < frames; f++) begin
				mark = need_mark || ($urandom_range(3) == 0);
				if ($urandom_range(7) == 0) begin
					send_raster($urandom_range(1, w * h - 1), mark, pct);
					need_mark = 1'b1;
				end else begin
					send_raster(w * h, mark, pct);
					need_mark = 1'b0;
				end
			end
		end
		sender_steady   = 1'b0;
		receiver_steady = 1'b0;
	endtask

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin
		width_reg  = FW_RESET;
		height_reg = FH_RESET;
		bits_reg   = PB_RESET;
		col_pos    = 0;
		row_pos    = 0;
		for (int y = 0; y < 5; y++)
			for (int x = 0; x < 5; x++)
				win[y][x] = '0;
		for (int s = 0; s < 4; s++)
			for (int c = 0; c < LINE_DEPTH; c++)
				line_mem[s][c] = '0;

		arst_n = 1'b0;
		repeat (6)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_extreme_pixels();
		test_frame_wrap();
		test_restart();
		test_degenerate_sizes();
		test_pixel_bits();
		test_hold_off();
		test_steady_stream();
		test_random_frames();
		wait_quiet();

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#15_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: bayer_malvar_demosaic.f
design/bmd_pkg.sv
design/bmd_ram.sv
design/bayer_malvar_demosaic.sv
dv/tb_bayer_malvar_demosaic.sv
